/* design/tga_pkg.sv */
// tga_pkg: shared types, constants and pixel conversion functions for the
// tga pixel stream decoder; no dependencies
package tga_pkg;

  // size and position widths
  localparam int MAX_DIMENSION = 4096;
  localparam int DIM_W         = 13;
  localparam int POS_W         = 12;
  localparam int LEN_W         = 8;
  localparam int AREA_W        = 25;
  localparam int CFG_IDX_W     = 3;
  localparam int DIV_STEPS     = DIM_W;
  localparam int DIV_CNT_W     = 4;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXEL_SIZE_MODE = 3'd0,
    REG_RLE_ENABLE      = 3'd1,
    REG_ALPHA_ENABLE    = 3'd2,
    REG_ALPHA_BIT_COUNT = 3'd3,
    REG_IMAGE_WIDTH     = 3'd4,
    REG_IMAGE_HEIGHT    = 3'd5,
    REG_FLIP_ROWS       = 3'd6
  } cfg_reg_t;

  // pixel size codes
  typedef enum logic [1:0] {
    PIX_GRAY8  = 2'd0,
    PIX_RGB16  = 2'd1,
    PIX_RGB24  = 2'd2,
    PIX_RGBA32 = 2'd3
  } pix_mode_t;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  // saturate a size register into 1..MAX_DIMENSION
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIMENSION)) begin
      r = DIM_W'(MAX_DIMENSION);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // replicate the low n alpha bits from the top down, n in 1..7
  function automatic logic [7:0] widen_alpha(input logic [7:0] a, input logic [3:0] n);
    logic [7:0] r;
    int         j;
    r = a;
    for (int k = 1; k < 8; k++) begin
      if (n == 4'(k)) begin
        // walk the pattern bits downward, wrapping back to the top one
        j = k - 1;
        for (int i = 0; i < 8; i++) begin
          r[7-i] = a[j];
          j = (j == 0) ? k - 1 : j - 1;
        end
      end
    end
    return r;
  endfunction

  // assembled pixel word to argb
  function automatic logic [31:0] make_argb(input pix_mode_t mode, input logic alpha_en,
                                            input logic [3:0] alpha_bits,
                                            input logic [31:0] px);
    logic [31:0] r;
    logic [7:0]  a;
    a = ALPHA_OPAQUE;
    case (mode)
      PIX_GRAY8: begin
        r = {ALPHA_OPAQUE, px[7:0], px[7:0], px[7:0]};
      end
      PIX_RGB16: begin
        if (alpha_en && px[15]) a = 8'h00;
        r = {a, px[14:10], px[14:12], px[9:5], px[9:7], px[4:0], px[4:2]};
      end
      PIX_RGB24: begin
        r = {ALPHA_OPAQUE, px[23:0]};
      end
      PIX_RGBA32: begin
        if (alpha_en) a = widen_alpha(px[31:24], alpha_bits);
        r = {a, px[23:0]};
      end
      default: begin
        r = {ALPHA_OPAQUE, px[23:0]};
      end
    endcase
    return r;
  endfunction

endpackage

/* design/tga_pixel_stream_decoder_core.sv */
// tga_pixel_stream_decoder_core: decodes the tga pixel-data byte stream into
// argb runs with destination position; depends on tga_pkg
//
// output: a result enters the output register in the cycle after the byte that completes it
// throughput: one byte per cycle while the output is not stalled; a run whose end lies two
// or more rows past its start (only with narrow images) holds the input while the restoring
// row/column divider works out the new position
// reset: synchronous, clears decoder and packet state and loads register defaults
module tga_pixel_stream_decoder_core (
  input  logic                        clk,
  input  logic                        rst,
  // input byte channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  data_byte,
  input  logic                        image_start,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [31:0]                 pixel_argb,
  output logic [tga_pkg::POS_W-1:0]   dest_row,
  output logic [tga_pkg::POS_W-1:0]   dest_column,
  output logic [tga_pkg::LEN_W-1:0]   run_length,
  output logic                        image_done,
  // configuration write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tga_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tga_pkg::DIM_W-1:0]   cfg_data
);
  import tga_pkg::*;

  // configuration registers
  pix_mode_t        pixel_size_mode;
  logic             rle_enable;
  logic             alpha_enable;
  logic [3:0]       alpha_bit_count;
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic             flip_rows;

  // decoder state
  logic [23:0]      byte_gather, byte_gather_next;
  logic [1:0]       byte_in_pixel, byte_in_pixel_next;
  logic             expect_packet_byte, expect_packet_byte_next;
  logic             packet_is_repeat, packet_is_repeat_next;
  logic [LEN_W-1:0] packet_pixels_left, packet_pixels_left_next;
  logic [POS_W-1:0] file_row, file_row_next;
  logic [POS_W-1:0] file_column, file_column_next;
  logic             image_complete, image_complete_next;

  // divider state
  logic                 div_busy;
  logic [DIV_CNT_W-1:0] div_count;
  logic [DIM_W-1:0]     div_num;
  logic [DIM_W-1:0]     div_den;
  logic [DIM_W-1:0]     div_rem;
  logic [DIM_W-1:0]     div_quo;

  // combinational results
  logic             in_accept;
  logic             res_valid;
  logic [31:0]      res_argb;
  logic [POS_W-1:0] res_row;
  logic [POS_W-1:0] res_column;
  logic [LEN_W-1:0] res_len;
  logic             res_done;
  logic             div_start;
  logic [DIM_W-1:0] div_start_num;

  logic [DIM_W-1:0]  w_eff, h_eff;
  logic [DIM_W-1:0]  rows_below;
  logic [AREA_W-1:0] area_below;
  logic [AREA_W-1:0] remaining;
  logic [31:0]       px;
  logic [LEN_W-1:0]  len_raw;
  logic [DIM_W-1:0]  run_end;
  logic [DIM_W-1:0]  run_end_wrap;
  logic [DIM_W-1:0]  flipped_row;

  logic [DIM_W:0]    div_trial;
  logic [DIM_W:0]    div_shift;
  logic [DIM_W-1:0]  div_rem_next;
  logic [DIM_W-1:0]  div_quo_next;

  assign w_eff = clamp_dim(image_width);
  assign h_eff = clamp_dim(image_height);

  // handshakes
  assign cfg_ready = 1'b1;
  assign in_stall  = div_busy | (out_valid & out_stall);
  assign in_accept = in_valid & ~in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_size_mode <= PIX_RGBA32;
      rle_enable      <= 1'b0;
      alpha_enable    <= 1'b0;
      alpha_bit_count <= 4'd8;
      image_width     <= DIM_W'(1);
      image_height    <= DIM_W'(1);
      flip_rows       <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_PIXEL_SIZE_MODE: pixel_size_mode <= pix_mode_t'(cfg_data[1:0]);
        REG_RLE_ENABLE:      rle_enable      <= cfg_data[0];
        REG_ALPHA_ENABLE:    alpha_enable    <= cfg_data[0];
        REG_ALPHA_BIT_COUNT: alpha_bit_count <= cfg_data[3:0];
        REG_IMAGE_WIDTH:     image_width     <= cfg_data;
        REG_IMAGE_HEIGHT:    image_height    <= cfg_data;
        REG_FLIP_ROWS:       flip_rows       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // area left below the current row, from the start-cleared position
  always_comb begin
    logic [POS_W-1:0] row_cur;
    logic [POS_W-1:0] col_cur;
    row_cur     = image_start ? '0 : file_row;
    col_cur     = image_start ? '0 : file_column;
    rows_below  = h_eff - {1'b0, row_cur} - DIM_W'(1);
    area_below  = {{(AREA_W-POS_W){1'b0}}, rows_below[POS_W-1:0]}
                * {{(AREA_W-DIM_W){1'b0}}, w_eff};
    remaining   = area_below + {{(AREA_W-DIM_W){1'b0}}, w_eff - {1'b0, col_cur}};
    flipped_row = h_eff - {1'b0, row_cur} - DIM_W'(1);
  end

  // byte decode: packet headers, pixel assembly, run placement
  always_comb begin
    byte_gather_next        = byte_gather;
    byte_in_pixel_next      = byte_in_pixel;
    expect_packet_byte_next = expect_packet_byte;
    packet_is_repeat_next   = packet_is_repeat;
    packet_pixels_left_next = packet_pixels_left;
    file_row_next           = file_row;
    file_column_next        = file_column;
    image_complete_next     = image_complete;
    if (image_start) begin
      byte_gather_next        = '0;
      byte_in_pixel_next      = '0;
      expect_packet_byte_next = 1'b1;
      packet_is_repeat_next   = 1'b0;
      packet_pixels_left_next = '0;
      file_row_next           = '0;
      file_column_next        = '0;
      image_complete_next     = 1'b0;
    end

    res_valid     = 1'b0;
    res_argb      = '0;
    res_row       = '0;
    res_column    = '0;
    res_len       = '0;
    res_done      = 1'b0;
    div_start     = 1'b0;
    div_start_num = '0;
    px            = '0;
    len_raw       = LEN_W'(1);
    run_end       = '0;
    run_end_wrap  = '0;

    if (!image_complete_next) begin
      if ({1'b0, file_row_next} >= h_eff || {1'b0, file_column_next} >= w_eff) begin
        // position left the image after a size change
        image_complete_next = 1'b1;
      end else if (rle_enable && (expect_packet_byte_next || packet_pixels_left_next == '0)) begin
        // packet header byte
        packet_is_repeat_next   = data_byte[7];
        packet_pixels_left_next = {1'b0, data_byte[6:0]} + LEN_W'(1);
        expect_packet_byte_next = 1'b0;
        byte_gather_next        = '0;
        byte_in_pixel_next      = '0;
      end else if (byte_in_pixel_next < pixel_size_mode) begin
        // gather a pixel byte
        case (byte_in_pixel_next)
          2'd0:    byte_gather_next[7:0]   = byte_gather_next[7:0]   | data_byte;
          2'd1:    byte_gather_next[15:8]  = byte_gather_next[15:8]  | data_byte;
          2'd2:    byte_gather_next[23:16] = byte_gather_next[23:16] | data_byte;
          default: ;
        endcase
        byte_in_pixel_next = byte_in_pixel_next + 2'd1;
      end else begin
        // last byte of a pixel
        case (pixel_size_mode)
          PIX_GRAY8:  px = {24'd0, data_byte};
          PIX_RGB16:  px = {16'd0, data_byte, byte_gather_next[7:0]};
          PIX_RGB24:  px = {8'd0, data_byte, byte_gather_next[15:0]};
          PIX_RGBA32: px = {data_byte, byte_gather_next[23:0]};
          default:    px = {data_byte, byte_gather_next[23:0]};
        endcase
        byte_gather_next   = '0;
        byte_in_pixel_next = '0;

        if (rle_enable) begin
          if (packet_is_repeat_next) begin
            len_raw                 = packet_pixels_left_next;
            packet_pixels_left_next = '0;
          end else begin
            packet_pixels_left_next = packet_pixels_left_next - LEN_W'(1);
          end
          if (packet_pixels_left_next == '0) expect_packet_byte_next = 1'b1;
        end

        // clip to the rest of the image
        res_len = len_raw;
        if ({{(AREA_W-LEN_W){1'b0}}, len_raw} > remaining) res_len = remaining[LEN_W-1:0];
        res_done   = ({{(AREA_W-LEN_W){1'b0}}, res_len} == remaining);
        res_valid  = 1'b1;
        res_argb   = make_argb(pixel_size_mode, alpha_enable, alpha_bit_count, px);
        res_row    = flip_rows ? flipped_row[POS_W-1:0] : file_row_next;
        res_column = file_column_next;

        // advance the position
        run_end      = {1'b0, file_column_next} + {{(DIM_W-LEN_W){1'b0}}, res_len};
        run_end_wrap = run_end - w_eff;
        if (res_done) begin
          image_complete_next = 1'b1;
          file_row_next       = h_eff[POS_W-1:0] - POS_W'(1);
          file_column_next    = w_eff[POS_W-1:0] - POS_W'(1);
        end else if (run_end < w_eff) begin
          file_column_next = run_end[POS_W-1:0];
        end else if (run_end_wrap < w_eff) begin
          file_row_next    = file_row_next + POS_W'(1);
          file_column_next = run_end_wrap[POS_W-1:0];
        end else begin
          div_start     = 1'b1;
          div_start_num = run_end;
        end
      end
    end
  end

  // restoring divider step for runs that cross several rows
  always_comb begin
    div_shift = {div_rem, div_num[DIM_W-1]};
    div_trial = div_shift - {1'b0, div_den};
    if (div_shift >= {1'b0, div_den}) begin
      div_rem_next = div_trial[DIM_W-1:0];
      div_quo_next = {div_quo[DIM_W-2:0], 1'b1};
    end else begin
      div_rem_next = div_shift[DIM_W-1:0];
      div_quo_next = {div_quo[DIM_W-2:0], 1'b0};
    end
  end

  // decoder state and divider registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_gather        <= '0;
      byte_in_pixel      <= '0;
      expect_packet_byte <= 1'b1;
      packet_is_repeat   <= 1'b0;
      packet_pixels_left <= '0;
      file_row           <= '0;
      file_column        <= '0;
      image_complete     <= 1'b0;
      div_busy           <= 1'b0;
      div_count          <= '0;
    end else if (in_accept) begin
      byte_gather        <= byte_gather_next;
      byte_in_pixel      <= byte_in_pixel_next;
      expect_packet_byte <= expect_packet_byte_next;
      packet_is_repeat   <= packet_is_repeat_next;
      packet_pixels_left <= packet_pixels_left_next;
      file_row           <= file_row_next;
      file_column        <= file_column_next;
      image_complete     <= image_complete_next;
      if (div_start) begin
        div_busy  <= 1'b1;
        div_count <= DIV_CNT_W'(DIV_STEPS - 1);
      end
    end else if (div_busy) begin
      div_count <= div_count - DIV_CNT_W'(1);
      if (div_count == '0) begin
        div_busy    <= 1'b0;
        file_row    <= file_row + div_quo_next[POS_W-1:0];
        file_column <= div_rem_next[POS_W-1:0];
      end
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (in_accept && div_start) begin
      div_num <= div_start_num;
      div_den <= w_eff;
      div_rem <= '0;
      div_quo <= '0;
    end else if (div_busy) begin
      div_num <= {div_num[DIM_W-2:0], 1'b0};
      div_rem <= div_rem_next;
      div_quo <= div_quo_next;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_accept && res_valid) begin
      pixel_argb  <= res_argb;
      dest_row    <= res_row;
      dest_column <= res_column;
      run_length  <= res_len;
      image_done  <= res_done;
    end
  end

endmodule

/* bench/tga_pixel_stream_decoder_core_checker.sv */
// tga_run_checker: watches the byte, result and register channels of the tga decoder,
// predicts every argb run from the accepted bytes and compares it field by field
// depends on tga_pkg
module tga_run_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [7:0]                    data_byte,
  input  logic                          image_start,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [31:0]                   pixel_argb,
  input  logic [tga_pkg::POS_W-1:0]     dest_row,
  input  logic [tga_pkg::POS_W-1:0]     dest_column,
  input  logic [tga_pkg::LEN_W-1:0]     run_length,
  input  logic                          image_done,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [tga_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tga_pkg::DIM_W-1:0]     cfg_data,
  output int                            errors,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tga_pkg::*;

  localparam int MAX_PRINTED = 40;

  typedef struct {
    logic [31:0]      argb;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] column;
    logic [LEN_W-1:0] length;
    logic             last;
  } run_t;

  run_t expected_runs[$];

  // register copy
  pix_mode_t        size_mode;
  logic             rle_on;
  logic             alpha_on;
  logic [3:0]       alpha_bits;
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic             flip_on;

  // decoder state copy
  logic [23:0]      gather;
  logic [1:0]       gathered;
  logic             want_packet;
  logic             packet_repeat;
  logic [7:0]       packet_left;
  int unsigned      row_pos;
  int unsigned      col_pos;
  logic             finished;

  function automatic int unsigned dim_limit(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIMENSION) return MAX_DIMENSION;
    return {19'd0, v};
  endfunction

  // low n alpha bits repeated end to end, top eight bits kept
  function automatic logic [7:0] stretch_alpha(input logic [7:0] a, input logic [3:0] n);
    int unsigned pattern, acc, filled;
    if (n < 1 || n > 7) return a;
    pattern = a & ((1 << n) - 1);
    acc = 0;
    filled = 0;
    while (filled < 8) begin
      acc = (acc << n) | pattern;
      filled += n;
    end
    return 8'(acc >> (filled - 8));
  endfunction

  function automatic logic [7:0] five_to_eight(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

  function automatic logic [31:0] to_argb(input logic [31:0] px);
    logic [7:0] a;
    case (size_mode)
      PIX_GRAY8: begin
        return {8'hff, px[7:0], px[7:0], px[7:0]};
      end
      PIX_RGB16: begin
        a = (alpha_on && px[15]) ? 8'h00 : 8'hff;
        return {a, five_to_eight(px[14:10]), five_to_eight(px[9:5]), five_to_eight(px[4:0])};
      end
      PIX_RGB24: begin
        return {8'hff, px[23:0]};
      end
      default: begin
        a = alpha_on ? stretch_alpha(px[31:24], alpha_bits) : 8'hff;
        return {a, px[23:0]};
      end
    endcase
  endfunction

  task automatic restore_defaults();
    size_mode     = PIX_RGBA32;
    rle_on        = 1'b0;
    alpha_on      = 1'b0;
    alpha_bits    = 4'd8;
    width_reg     = DIM_W'(1);
    height_reg    = DIM_W'(1);
    flip_on       = 1'b1;
    gather        = '0;
    gathered      = '0;
    want_packet   = 1'b1;
    packet_repeat = 1'b0;
    packet_left   = '0;
    row_pos       = 0;
    col_pos       = 0;
    finished      = 1'b0;
  endtask

  task automatic apply_register(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] v);
    case (idx)
      REG_PIXEL_SIZE_MODE: size_mode  = pix_mode_t'(v[1:0]);
      REG_RLE_ENABLE:      rle_on     = v[0];
      REG_ALPHA_ENABLE:    alpha_on   = v[0];
      REG_ALPHA_BIT_COUNT: alpha_bits = v[3:0];
      REG_IMAGE_WIDTH:     width_reg  = v;
      REG_IMAGE_HEIGHT:    height_reg = v;
      REG_FLIP_ROWS:       flip_on    = v[0];
      default: ;
    endcase
  endtask

  // one accepted byte: update state, queue the run it completes if any
  task automatic decode_byte(input logic [7:0] b, input logic start);
    int unsigned w, h, remaining, len, run_end;
    logic [31:0] px;
    run_t run;
    w = dim_limit(width_reg);
    h = dim_limit(height_reg);
    if (start) begin
      gather        = '0;
      gathered      = '0;
      want_packet   = 1'b1;
      packet_repeat = 1'b0;
      packet_left   = '0;
      row_pos       = 0;
      col_pos       = 0;
      finished      = 1'b0;
    end
    if (finished) return;
    // position left outside a shrunken image
    if (row_pos >= h || col_pos >= w) begin
      finished = 1'b1;
      return;
    end
    // packet header
    if (rle_on && (want_packet || packet_left == 0)) begin
      packet_repeat = b[7];
      packet_left   = {1'b0, b[6:0]} + 8'd1;
      want_packet   = 1'b0;
      gather        = '0;
      gathered      = '0;
      return;
    end
    // gather pixel bytes, low byte first
    if (gathered < size_mode) begin
      gather   = gather | (24'(b) << (8 * gathered));
      gathered = gathered + 2'd1;
      return;
    end
    case (size_mode)
      PIX_GRAY8: px = {24'h0, b};
      PIX_RGB16: px = {16'h0, b, gather[7:0]};
      PIX_RGB24: px = {8'h0, b, gather[15:0]};
      default:   px = {b, gather[23:0]};
    endcase
    gather   = '0;
    gathered = '0;
    len = 1;
    if (rle_on) begin
      if (packet_repeat) begin
        len = {24'd0, packet_left};
        packet_left = '0;
      end else begin
        packet_left = packet_left - 8'd1;
      end
      if (packet_left == 0) want_packet = 1'b1;
    end
    // clip to the pixels left in the image
    remaining = (h - row_pos - 1) * w + (w - col_pos);
    if (len > remaining) len = remaining;
    run.argb   = to_argb(px);
    run.row    = POS_W'(flip_on ? (h - 1 - row_pos) : row_pos);
    run.column = POS_W'(col_pos);
    run.length = LEN_W'(len);
    run.last   = (len == remaining);
    expected_runs.push_back(run);
    if (len == remaining) begin
      finished = 1'b1;
      row_pos  = h - 1;
      col_pos  = w - 1;
    end else begin
      run_end = col_pos + len;
      row_pos = row_pos + run_end / w;
      col_pos = run_end % w;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    // keep the log short when everything goes wrong
    if (errors <= MAX_PRINTED) begin
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    end
  endtask

  // result compare first, then register write, then prediction
  always @(posedge clk) begin
    run_t want;
    if (rst) begin
      restore_defaults();
      expected_runs.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_runs.size() == 0) begin
          report_mismatch("unexpected run, argb", pixel_argb, 32'h0);
        end else begin
          want = expected_runs.pop_front();
          if (pixel_argb !== want.argb) report_mismatch("pixel_argb", pixel_argb, want.argb);
          if (dest_row !== want.row) begin
            report_mismatch("dest_row", 32'(dest_row), 32'(want.row));
          end
          if (dest_column !== want.column) begin
            report_mismatch("dest_column", 32'(dest_column), 32'(want.column));
          end
          if (run_length !== want.length) begin
            report_mismatch("run_length", 32'(run_length), 32'(want.length));
          end
          if (image_done !== want.last) begin
            report_mismatch("image_done", 32'(image_done), 32'(want.last));
          end
        end
      end
      if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
      if (in_valid && !in_stall) decode_byte(data_byte, image_start);
    end
    pending <= expected_runs.size();
  end

endmodule

/* bench/tga_pixel_stream_decoder_core_tb.sv */
// tga_pixel_stream_decoder_core_tb: drives byte streams, register settings and output
// back-pressure into the tga decoder and gives the verdict
// depends on tga_pkg, tga_pixel_stream_decoder_core and tga_run_checker
module tga_pixel_stream_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tga_pkg::*;

  localparam int IDLE_PCT       = 27;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS   = 1900;
  localparam int CALM_PHASE     = 4;
  localparam int HOLD_PHASE     = 7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct {
    pix_mode_t        mode;
    logic             rle;
    logic             alpha;
    logic [3:0]       abits;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic             flip;
  } setup_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           data_byte = 8'h00;
  logic                 image_start = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [31:0]          pixel_argb;
  logic [POS_W-1:0]     dest_row;
  logic [POS_W-1:0]     dest_column;
  logic [LEN_W-1:0]     run_length;
  logic                 image_done;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;

  int          errors;
  int          pending;
  int          hold_requests = 0;
  int          holds_served = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  int unsigned counted = 0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;
  setup_t      cur;

  tga_pixel_stream_decoder_core uut (.*);

  tga_run_checker run_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
    .image_start(image_start),
    .out_valid(out_valid), .out_stall(out_stall), .pixel_argb(pixel_argb),
    .dest_row(dest_row), .dest_column(dest_column), .run_length(run_length),
    .image_done(image_done),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, or a long counted hold-off on request
  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !recv_calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tga_pixel_stream_decoder_core test failed");
      $finish;
    end
  end

  function automatic int unsigned usable_dim(input logic [DIM_W-1:0] v);
    return (v == '0) ? 1 : ((v > MAX_DIMENSION) ? MAX_DIMENSION : v);
  endfunction

  function automatic setup_t make_setup(input pix_mode_t m, input logic rle, input logic alpha,
                                        input logic [3:0] abits, input logic [DIM_W-1:0] w,
                                        input logic [DIM_W-1:0] h, input logic flip);
    setup_t s;
    s.mode  = m;
    s.rle   = rle;
    s.alpha = alpha;
    s.abits = abits;
    s.w     = w;
    s.h     = h;
    s.flip  = flip;
    return s;
  endfunction

  // mostly tiny images, a few wide ones and out of range sizes
  function automatic logic [DIM_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return DIM_W'($urandom_range(8, 1));
    if (r < 90) return DIM_W'($urandom_range(40, 9));
    case ($urandom_range(3))
      0: return '0;
      1: return DIM_W'(MAX_DIMENSION);
      2: return '1;
      default: return DIM_W'($urandom_range(8191, 1));
    endcase
  endfunction

  function automatic logic [7:0] pixel_value();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom_range(255));
  endfunction

  // byte transaction, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic start);
    while (!send_calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    data_byte   <= b;
    image_start <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // register transaction, valid left high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // all registers, unused upper data bits filled with noise
  task automatic configure(input setup_t s, input bit with_spare);
    write_reg(REG_PIXEL_SIZE_MODE, {11'($urandom), s.mode});
    write_reg(REG_RLE_ENABLE, {12'($urandom), s.rle});
    write_reg(REG_ALPHA_ENABLE, {12'($urandom), s.alpha});
    write_reg(REG_ALPHA_BIT_COUNT, {9'($urandom), s.abits});
    write_reg(REG_IMAGE_WIDTH, s.w);
    write_reg(REG_IMAGE_HEIGHT, s.h);
    write_reg(REG_FLIP_ROWS, {12'($urandom), s.flip});
    if (with_spare) write_reg(REG_SPARE, DIM_W'($urandom_range(8191)));
    cfg_valid <= 1'b0;
    cur = s;
  endtask

  // sender pause until every run has come out, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_list(input logic [7:0] bytes[$], input bit fresh);
    foreach (bytes[i]) send_byte(bytes[i], fresh && i == 0);
  endtask

  task automatic image_byte(input logic [7:0] b, inout bit first, inout int unsigned sent,
                            input int unsigned cap);
    if (sent < cap) begin
      // rare restart in the middle of an image
      send_byte(b, first || $urandom_range(99) == 0);
      first = 1'b0;
      sent++;
      counted++;
    end
  endtask

  // well-formed pixel data for the current setting, cut off at cap bytes
  task automatic send_image(input bit fresh, input int unsigned cap, output bit cut_short);
    int unsigned area, covered, sent, count, npix, bpp;
    bit first;
    logic rep;
    area = usable_dim(cur.w) * usable_dim(cur.h);
    bpp = int'(cur.mode) + 1;
    covered = 0;
    sent = 0;
    first = fresh;
    while (covered < area && sent < cap) begin
      if (cur.rle) begin
        count = ($urandom_range(9) < 7) ? $urandom_range(7) : $urandom_range(127);
        rep = 1'($urandom_range(1));
        image_byte({rep, count[6:0]}, first, sent, cap);
        npix = rep ? 1 : count + 1;
        covered += count + 1;
      end else begin
        npix = 1;
        covered++;
      end
      repeat (npix * bpp) image_byte(pixel_value(), first, sent, cap);
    end
    cut_short = (covered < area) || (sent >= cap);
  endtask

  initial begin
    setup_t s;
    int phase, nimg, tail;
    int unsigned cap;
    bit resume, cut;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: one 32-bit pixel fills the 1x1 image, next byte is ignored
    send_list('{8'h10, 8'h20, 8'h30, 8'h40, 8'h55}, 1'b1);
    drain();

    // gray, 3x2 bottom-up
    configure(make_setup(PIX_GRAY8, 1'b0, 1'b0, 4'd8, 13'd3, 13'd2, 1'b1), 1'b1);
    send_list('{8'h00, 8'hff, 8'h5a, 8'ha5, 8'h01, 8'h80}, 1'b1);
    drain();

    // 16-bit packets: repeat with alpha bit set, then a raw white pixel
    configure(make_setup(PIX_RGB16, 1'b1, 1'b1, 4'd0, 13'd3, 13'd1, 1'b0), 1'b0);
    send_list('{8'h81, 8'h00, 8'h80, 8'h00, 8'hff, 8'h7f}, 1'b1);
    drain();

    // saturated sizes, longest repeat packet
    configure(make_setup(PIX_RGB24, 1'b1, 1'b0, 4'd15, 13'd0, 13'h1fff, 1'b1), 1'b0);
    send_list('{8'hff, 8'h11, 8'h22, 8'h33}, 1'b1);
    drain();

    // largest image, one-bit alpha
    configure(make_setup(PIX_RGBA32, 1'b0, 1'b1, 4'd1, 13'd4096, 13'd4096, 1'b0), 1'b0);
    send_list('{8'h01, 8'h02, 8'h03, 8'hfe}, 1'b1);
    drain();

    // size lowered under the current position: byte gives no run
    configure(make_setup(PIX_RGBA32, 1'b0, 1'b1, 4'd7, 13'd1, 13'd1, 1'b0), 1'b0);
    send_list('{8'h9c}, 1'b0);
    drain();

    // random phases: fresh settings, images with random content
    phase = 0;
    resume = 1'b0;
    while (counted < RANDOM_ITEMS || phase <= HOLD_PHASE) begin
      s.mode  = pix_mode_t'($urandom_range(3));
      s.rle   = $urandom_range(99) < 65;
      s.alpha = 1'($urandom_range(1));
      s.abits = 4'($urandom_range(15));
      s.w     = pick_dim();
      s.h     = pick_dim();
      s.flip  = 1'($urandom_range(1));
      if (phase == HOLD_PHASE) s = make_setup(PIX_GRAY8, 1'b0, 1'b0, 4'd8, 13'd8, 13'd8, 1'b0);
      configure(s, $urandom_range(5) == 0);
      send_calm = (phase == CALM_PHASE) || (phase == HOLD_PHASE);
      recv_calm <= (phase == CALM_PHASE);
      nimg = (phase == CALM_PHASE) ? 3 : $urandom_range(3, 1);
      if (phase == HOLD_PHASE) begin
        hold_requests <= hold_requests + 1;
        resume = 1'b0;
        nimg = 2;
      end
      for (int i = 0; i < nimg; i++) begin
        cap = (usable_dim(cur.w) * usable_dim(cur.h) > 64) ? 200 : 400;
        // leave an image part way, often inside a pixel, for the next setting
        if (i == nimg - 1 && phase != HOLD_PHASE && $urandom_range(5) == 0) begin
          cap = $urandom_range(15, 1);
        end
        send_image(!resume, cap, cut);
        resume = cut;
        if (!resume && $urandom_range(3) == 0) begin
          tail = $urandom_range(3, 1);
          repeat (tail) send_byte(pixel_value(), 1'b0);
        end
      end
      drain();
      phase++;
    end

    send_calm = 1'b0;
    recv_calm <= 1'b0;
    drain();
    if (errors == 0) begin
      $display("tga_pixel_stream_decoder_core test passed");
    end else begin
      $display("tga_pixel_stream_decoder_core test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
design/tga_pkg.sv
design/tga_pixel_stream_decoder_core.sv
bench/tga_pixel_stream_decoder_core_checker.sv
bench/tga_pixel_stream_decoder_core_tb.sv
